// ----- src/tel_pkg.sv -----
// Package: shared types, widths and codes of the time-ordered event list.
package tel_pkg;

    // List geometry
    localparam int LIST_DEPTH = 32;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);

    // Field widths
    localparam int TIME_W   = 32;
    localparam int TARGET_W = 16;
    localparam int KIND_W   = 8;
    localparam int DATA_W   = TIME_W + TARGET_W + KIND_W;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_FRONT   = 2'd0;
    localparam logic [OP_W-1:0] OP_BACK    = 2'd1;
    localparam logic [OP_W-1:0] OP_ORDERED = 2'd2;
    localparam logic [OP_W-1:0] OP_READ    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // One event; time sits in the lowest bits when packed
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [TARGET_W-1:0] target;
        logic [TIME_W-1:0]   time_val;
    } entry_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic            ins_en;
        logic            rot_en;
        logic [OP_W-1:0] op;
        entry_t          new_entry;
    } cell_ctrl_t;

endpackage

// ----- src/tel_cell.sv -----
// One cell of the event chain: holds a single entry and shifts with its neighbours.
module tel_cell (
    input  logic               clk,
    input  tel_pkg::cell_ctrl_t ctrl,
    input  logic               is_head,
    input  logic               occ,
    input  logic               is_tail,
    input  logic               prior_hit,
    output logic               hit_out,
    input  tel_pkg::entry_t    left_entry,
    input  tel_pkg::entry_t    right_entry,
    input  tel_pkg::entry_t    head_entry,
    output tel_pkg::entry_t    entry
);
    import tel_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;

    // Decide whether the insert position lands on this cell
    always_comb
    begin
        unique case (ctrl.op)
            OP_FRONT:   hit = is_head;
            OP_BACK:    hit = !occ;
            OP_ORDERED: hit = !occ ||
                              (is_head ? (entry_reg.time_val > ctrl.new_entry.time_val)
                                       : (entry_reg.time_val >= ctrl.new_entry.time_val));
            default:    hit = 1'b0;
        endcase
    end

    assign hit_out = prior_hit | hit;

    // Shift up behind the insert point, load the new event at it, rotate on readout
    always_comb
    begin
        priority if (ctrl.ins_en && prior_hit)
            entry_next = left_entry;
        else if (ctrl.ins_en && hit)
            entry_next = ctrl.new_entry;
        else if (ctrl.rot_en)
            entry_next = is_tail ? head_entry : right_entry;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- src/time_ordered_event_list.sv -----
// Top level: event list built as a chain of shifting cells, with stream ports.
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  tuser: opcode; tdata: time, target, kind
//  m_*      out  m_tvalid/m_tready  tuser: status; tdata: time, target, kind; tlast
//
// On an insert the cells at and behind the insert point all shift in the same
// edge, and the status beat is registered at that edge.
// A readout of a non-empty list first enters the read state, then gives one entry
// per cycle while the output is not stalled; an empty list registers its single
// beat in the accepting cycle. The chain rotates one place per beat, so after the
// last beat the list is back in order. No new beat is taken while a readout is
// running. Reset empties the list at once; entry contents are not cleared.
// A stalled output holds its beat; the input is taken again as soon as the
// output register is free or being drained.
module time_ordered_event_list (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tel_pkg::DATA_W-1:0]      s_tdata,   // event_time, event_target, event_kind
    input  logic [tel_pkg::OP_W-1:0]        s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tel_pkg::DATA_W-1:0]      m_tdata,   // out_time, out_target, out_kind
    output logic [tel_pkg::STATUS_W-1:0]    m_tuser,   // status
    output logic                            m_tlast
);
    import tel_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    entry_t              out_entry_reg, out_entry_next;
    logic                out_last_reg, out_last_next;

    logic                can_load;
    logic                in_acc;
    logic                full;
    logic                rd_last;
    cell_ctrl_t          ctrl;

    logic   [LIST_DEPTH-1:0] occ;
    logic   [LIST_DEPTH-1:0] is_tail;
    logic   [LIST_DEPTH:0]   hit_chain;
    entry_t                  cell_entry [LIST_DEPTH];

    assign can_load = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && can_load;
    assign in_acc   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(LIST_DEPTH));
    assign rd_last  = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    // Broadcast control to the chain
    always_comb
    begin
        ctrl.op        = s_tuser;
        ctrl.new_entry = entry_t'(s_tdata);
        ctrl.ins_en    = in_acc && (s_tuser != OP_READ) && !full;
        ctrl.rot_en    = (state_reg == S_READ) && can_load;
    end

    // Occupancy and tail marks from the fill count
    assign hit_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            assign occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == LIST_DEPTH - 1)
            begin : g_last
                assign is_tail[gi] = occ[gi];
                tel_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .is_head     (1'b0),
                    .occ         (occ[gi]),
                    .is_tail     (is_tail[gi]),
                    .prior_hit   (hit_chain[gi]),
                    .hit_out     (hit_chain[gi+1]),
                    .left_entry  (cell_entry[gi-1]),
                    .right_entry (cell_entry[0]),
                    .head_entry  (cell_entry[0]),
                    .entry       (cell_entry[gi])
                );
            end
            else if (gi == 0)
            begin : g_head
                assign is_tail[gi] = occ[gi] && !occ[gi+1];
                tel_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .is_head     (1'b1),
                    .occ         (occ[gi]),
                    .is_tail     (is_tail[gi]),
                    .prior_hit   (hit_chain[gi]),
                    .hit_out     (hit_chain[gi+1]),
                    .left_entry  (ctrl.new_entry),
                    .right_entry (cell_entry[gi+1]),
                    .head_entry  (cell_entry[0]),
                    .entry       (cell_entry[gi])
                );
            end
            else
            begin : g_mid
                assign is_tail[gi] = occ[gi] && !occ[gi+1];
                tel_cell u_cell (
                    .clk         (clk),
                    .ctrl        (ctrl),
                    .is_head     (1'b0),
                    .occ         (occ[gi]),
                    .is_tail     (is_tail[gi]),
                    .prior_hit   (hit_chain[gi]),
                    .hit_out     (hit_chain[gi+1]),
                    .left_entry  (cell_entry[gi-1]),
                    .right_entry (cell_entry[gi+1]),
                    .head_entry  (cell_entry[0]),
                    .entry       (cell_entry[gi])
                );
            end
        end
    endgenerate

    // Sequence inserts and readouts, load the output register
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == OP_READ)
                    begin
                        if (count_reg == '0)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_EMPTY;
                            out_entry_next  = '0;
                            out_last_next   = 1'b1;
                        end
                        else
                        begin
                            state_next  = S_READ;
                            rd_idx_next = '0;
                        end
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = full ? ST_FULL : ST_INSERTED;
                        out_entry_next  = '0;
                        out_last_next   = 1'b1;
                        if (!full)
                            count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            S_READ:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_ENTRY;
                    out_entry_next  = cell_entry[0];
                    out_last_next   = rd_last;
                    rd_idx_next     = rd_idx_reg + IDX_W'(1);
                    if (rd_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_entry_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/tel_checker.sv -----
// Checker: port-level assertions on the event list, bound to the top level.
module tel_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [tel_pkg::DATA_W-1:0]      s_tdata,
    input  logic [tel_pkg::OP_W-1:0]        s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tel_pkg::DATA_W-1:0]      m_tdata,
    input  logic [tel_pkg::STATUS_W-1:0]    m_tuser,
    input  logic                            m_tlast
);
    import tel_pkg::*;

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // Insert and empty-list beats carry zero data and close the item
    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_ENTRY) |-> (m_tdata == '0) && m_tlast)
        else $error("status beat with data or without last");

    // An insert gives its status beat in the next cycle
    a_insert_resp: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != OP_READ) |=>
            m_tvalid && m_tlast && ((m_tuser == ST_INSERTED) || (m_tuser == ST_FULL)))
        else $error("insert without status beat");

    // Take no input while a readout is still running
    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_ENTRY) && !m_tlast |-> !s_tready)
        else $error("input taken during readout");

endmodule

bind time_ordered_event_list tel_checker u_tel_checker (.*);
